### src/tfp_pkg.sv
// ----------------------------------------------------------------------------
// tfp_pkg
// shared constants and payload types of the telemetry frame parser
// ----------------------------------------------------------------------------
`default_nettype none

package tfp_pkg;

  // frame layout
  localparam int unsigned FRAME_BYTES = 24;
  localparam int unsigned CHECK_SPAN  = 22;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned FILL_W      = $clog2(FRAME_BYTES + 1);
  localparam int unsigned POS_W       = $clog2(FRAME_BYTES);

  // configuration registers
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEADER = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TAIL   = 1'b1;

  localparam logic [BYTE_W-1:0] HEADER_RESET = 8'hAA;
  localparam logic [BYTE_W-1:0] TAIL_RESET   = 8'h55;

  typedef struct packed {
    logic [7:0]  rx_byte;
    logic [63:0] stamp;
  } in_item_t;

  typedef struct packed {
    logic [63:0]        frame_stamp;
    logic [7:0]         status_byte;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic signed [15:0] yaw_rate;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] gyro_x;
    logic signed [15:0] gyro_y;
    logic signed [15:0] gyro_z;
    logic [15:0]        supply_level;
  } out_item_t;

endpackage

`default_nettype wire

### src/tfp_window.sv
// ----------------------------------------------------------------------------
// tfp_window
// 24-byte frame window: header search, checksum and tail check, realignment
// ----------------------------------------------------------------------------
`default_nettype none

module tfp_window (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          step_i,
  input  wire tfp_pkg::in_item_t             item_i,
  input  wire logic [tfp_pkg::BYTE_W-1:0]    header_i,
  input  wire logic [tfp_pkg::BYTE_W-1:0]    tail_i,
  output logic                               emit_o,
  output tfp_pkg::out_item_t                 frame_o
);

  localparam int unsigned NB = tfp_pkg::FRAME_BYTES;

  logic [tfp_pkg::BYTE_W-1:0] store_q [NB];
  logic [tfp_pkg::BYTE_W-1:0] store_d [NB];
  logic [tfp_pkg::BYTE_W-1:0] win     [NB];
  logic [tfp_pkg::FILL_W-1:0] fill_q, fill_d, fill_n;
  logic [NB-1:0]              hit, cand;
  logic [tfp_pkg::CHECK_SPAN-1:0] col;
  logic [tfp_pkg::BYTE_W-1:0] chk;
  logic                       full, good, drop_first, found;
  logic [tfp_pkg::POS_W-1:0]  sel;
  logic [tfp_pkg::FILL_W:0]   src;

  always_comb begin
    // window with the new byte appended
    for (int i = 0; i < NB; i++) begin
      win[i] = (tfp_pkg::FILL_W'(i) == fill_q) ? item_i.rx_byte : store_q[i];
    end
    fill_n = fill_q + tfp_pkg::FILL_W'(1);
    full   = (fill_n == tfp_pkg::FILL_W'(NB));

    for (int i = 0; i < NB; i++) begin
      hit[i] = (tfp_pkg::FILL_W'(i) < fill_n) && (win[i] == header_i);
    end

    // xor over bytes 0 to 21, one reduction per bit column
    col = '0;
    for (int b = 0; b < tfp_pkg::BYTE_W; b++) begin
      for (int i = 0; i < tfp_pkg::CHECK_SPAN; i++) begin
        col[i] = win[i][b];
      end
      chk[b] = ^col;
    end

    good       = (chk == win[tfp_pkg::CHECK_SPAN]) && (win[NB-1] == tail_i);
    emit_o     = full && hit[0] && good;
    drop_first = full && hit[0] && !good;

    // bad frame: skip its first byte and resync on the next header
    cand    = hit;
    cand[0] = hit[0] && !drop_first;

    found = 1'b0;
    sel   = '0;
    for (int i = NB - 1; i >= 0; i--) begin
      if (cand[i]) begin
        found = 1'b1;
        sel   = tfp_pkg::POS_W'(i);
      end
    end

    for (int i = 0; i < NB; i++) begin
      src = (tfp_pkg::FILL_W + 1)'(i) + (tfp_pkg::FILL_W + 1)'(sel);
      if (src < (tfp_pkg::FILL_W + 1)'(NB)) begin
        store_d[i] = win[src[tfp_pkg::FILL_W-1:0]];
      end else begin
        store_d[i] = win[i];
      end
    end

    if (emit_o || !found) begin
      fill_d = '0;
    end else begin
      fill_d = fill_n - tfp_pkg::FILL_W'(sel);
    end

    frame_o.frame_stamp  = item_i.stamp;
    frame_o.status_byte  = win[1];
    frame_o.vel_x        = {win[2],  win[3]};
    frame_o.vel_y        = {win[4],  win[5]};
    frame_o.yaw_rate     = {win[6],  win[7]};
    frame_o.accel_x      = {win[8],  win[9]};
    frame_o.accel_y      = {win[10], win[11]};
    frame_o.accel_z      = {win[12], win[13]};
    frame_o.gyro_x       = {win[14], win[15]};
    frame_o.gyro_y       = {win[16], win[17]};
    frame_o.gyro_z       = {win[18], win[19]};
    frame_o.supply_level = {win[20], win[21]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else if (step_i) begin
      fill_q <= fill_d;
    end
  end

  // byte storage, only entries below the fill count are ever looked at
  always_ff @(posedge clk_i) begin
    if (step_i) begin
      store_q <= store_d;
    end
  end

endmodule

`default_nettype wire

### src/tfp_out_stage.sv
// ----------------------------------------------------------------------------
// tfp_out_stage
// result register holding one decoded frame until the receiver takes it
// ----------------------------------------------------------------------------
`default_nettype none

module tfp_out_stage (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               load_i,
  input  wire tfp_pkg::out_item_t item_i,
  input  wire logic               out_stall_i,
  output logic                    out_valid_o,
  output tfp_pkg::out_item_t      out_item_o,
  output logic                    blocked_o
);

  logic               valid_q;
  tfp_pkg::out_item_t item_q;

  // a held result that is not taken this cycle blocks a new load
  assign blocked_o   = valid_q && out_stall_i;
  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      item_q <= item_i;
    end
  end

endmodule

`default_nettype wire

### src/telemetry_frame_parser_core.sv
// ----------------------------------------------------------------------------
// telemetry_frame_parser_core
// finds 24-byte telemetry frames in a timestamped serial byte stream
// ----------------------------------------------------------------------------
// usage
//   input channel: one received byte with its timestamp per item, valid/stall
//   output channel: one decoded frame per item, valid/stall
//   config port: cfg_we_i writes cfg_wdata_i to header (index 0) or tail
//     (index 1); the user must write only while the parser is idle; the core does not enforce it
// timing
//   one byte is taken every cycle unless stalled; the whole window update (header
//   search, xor check, realignment) happens in the cycle the byte is accepted
//   a frame appears on the output in the cycle after its last byte is accepted
// reset
//   window emptied, header back to 0xaa, tail back to 0x55, output empty
// stall
//   the result register holds a frame until it is taken; input is stalled
//   only while that register is full and the receiver stalls, since a new
//   byte could complete another frame
// ----------------------------------------------------------------------------
`default_nettype none

module telemetry_frame_parser_core (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // byte input
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire tfp_pkg::in_item_t                in_item_i,
  // frame output
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output tfp_pkg::out_item_t                    out_item_o,
  // configuration
  input  wire logic                             cfg_we_i,
  input  wire logic [tfp_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [tfp_pkg::BYTE_W-1:0]       cfg_wdata_i
);

  logic [tfp_pkg::BYTE_W-1:0] header_q, tail_q;
  logic                       step, emit, blocked;
  tfp_pkg::out_item_t         frame;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q <= tfp_pkg::HEADER_RESET;
      tail_q   <= tfp_pkg::TAIL_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tfp_pkg::CFG_HEADER: header_q <= cfg_wdata_i;
        tfp_pkg::CFG_TAIL:   tail_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign in_stall_o = blocked;
  assign step       = in_valid_i && !blocked;

  // window, search and frame checks
  tfp_window u_window (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (in_item_i),
    .header_i (header_q),
    .tail_i   (tail_q),
    .emit_o   (emit),
    .frame_o  (frame)
  );

  // result register
  tfp_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step && emit),
    .item_i      (frame),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o),
    .blocked_o   (blocked)
  );

endmodule

`default_nettype wire
